>>> rtl/core/mcam_pkg.sv
// Shared types and constants of the MIDI controller automation mapper.
package mcam_pkg;

    // Item kinds carried in the mode field.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_EVENT = 1'b1;

    // MIDI status byte decoding.
    localparam logic [7:0] STATUS_KIND_MASK = 8'hf0;
    localparam logic [7:0] STATUS_CC        = 8'hb0;
    localparam logic [7:0] CHANNEL_MASK     = 8'h0f;

    // Wildcard codes of the match fields (minus one in two's complement).
    localparam logic [4:0] ANY_CHANNEL    = 5'h1f;
    localparam logic [7:0] ANY_CONTROLLER = 8'hff;

    // Mapping data of one automation slot, as held in the slot memory.
    typedef struct packed {
        logic [6:0]         cc_min;
        logic [16:0]        cc_scale;
        logic [5:0]         target_port;
        logic               int_floor;
        logic signed [31:0] out_min;
        logic [30:0]        out_span;
        logic signed [31:0] out_max;
    } mcam_slot_t;

    // Control of one candidate beat handed from the slot scanner to the mapping pipeline.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] cc_value;
    } mcam_cand_t;

endpackage

>>> rtl/core/mcam_in_if.sv
// Input channel of the automation mapper: load and event items.
interface mcam_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [2:0]         slot;
    logic signed [4:0]  match_channel;
    logic signed [7:0]  match_controller;
    logic [6:0]         cc_min;
    logic [16:0]        cc_scale;
    logic [5:0]         target_port;
    logic signed [31:0] out_min;
    logic [30:0]        out_span;
    logic signed [31:0] out_max;
    logic               int_floor;
    logic [23:0]        midi_message;

    modport source (
        output valid, mode, slot, match_channel, match_controller, cc_min, cc_scale,
               target_port, out_min, out_span, out_max, int_floor, midi_message,
        input  ready
    );

    modport sink (
        input  valid, mode, slot, match_channel, match_controller, cc_min, cc_scale,
               target_port, out_min, out_span, out_max, int_floor, midi_message,
        output ready
    );
endinterface

>>> rtl/core/mcam_out_if.sv
// Output channel of the automation mapper: control port updates.
interface mcam_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         port_index;
    logic signed [31:0] port_value;
    logic               last;

    modport source (
        output valid, port_index, port_value, last,
        input  ready
    );

    modport sink (
        input  valid, port_index, port_value, last,
        output ready
    );
endinterface

>>> rtl/core/mcam_map_pipe.sv
// Four-stage mapping pipeline from controller value to clamped control port value.
module mcam_map_pipe
    import mcam_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  mcam_cand_t cand,
    input  mcam_slot_t slot_data,
    output logic       advance,
    mcam_out_if.source result
);

    localparam int REL_W  = FRAC_BITS + 1;
    localparam int PROD_W = FRAC_BITS + 32;
    localparam logic signed [26:0] REL_ONE = 27'sd1 <<< FRAC_BITS;

    // Stage registers.
    logic               s2_valid_reg, s2_valid_next;
    logic               s2_last_reg, s2_last_next;
    logic [REL_W-1:0]   s2_rel_reg, s2_rel_next;
    mcam_slot_t         s2_slot_reg, s2_slot_next;

    logic               s3_valid_reg, s3_valid_next;
    logic               s3_last_reg, s3_last_next;
    logic [30:0]        s3_scaled_reg, s3_scaled_next;
    mcam_slot_t         s3_slot_reg, s3_slot_next;

    logic               s4_valid_reg, s4_valid_next;
    logic               s4_last_reg, s4_last_next;
    logic signed [32:0] s4_sum_reg, s4_sum_next;
    mcam_slot_t         s4_slot_reg, s4_slot_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    logic [5:0]         out_index_reg, out_index_next;
    logic signed [31:0] out_value_reg, out_value_next;

    // Combinational intermediates.
    logic signed [26:0]  cc_diff;
    logic signed [26:0]  scale_ext;
    logic signed [26:0]  rel_raw;
    logic [PROD_W-1:0]   span_prod;
    logic signed [32:0]  raw_sum;
    logic signed [32:0]  lo_ext;
    logic signed [32:0]  hi_ext;

    // The whole pipeline moves together whenever the output register can take a beat.
    assign advance = !out_valid_reg || result.ready;

    // Stage 1: relative level from the controller value, clamped to zero..one.
    always_comb
    begin
        cc_diff   = $signed({19'd0, cand.cc_value}) - $signed({20'd0, slot_data.cc_min});
        scale_ext = $signed({10'd0, slot_data.cc_scale});
        rel_raw   = cc_diff * scale_ext;
        if (rel_raw < 0)
        begin
            s2_rel_next = '0;
        end
        else if (rel_raw > REL_ONE)
        begin
            s2_rel_next = REL_ONE[REL_W-1:0];
        end
        else
        begin
            s2_rel_next = rel_raw[REL_W-1:0];
        end
        s2_valid_next = cand.valid;
        s2_last_next  = cand.last;
        s2_slot_next  = slot_data;
    end

    // Stage 2: scale the relative level by the port span.
    always_comb
    begin
        span_prod      = PROD_W'(s2_rel_reg) * PROD_W'(s2_slot_reg.out_span);
        s3_scaled_next = span_prod[FRAC_BITS+30:FRAC_BITS];
        s3_valid_next  = s2_valid_reg;
        s3_last_next   = s2_last_reg;
        s3_slot_next   = s2_slot_reg;
    end

    // Stage 3: add the port minimum and floor integer ports toward minus infinity.
    always_comb
    begin
        raw_sum = $signed({s3_slot_reg.out_min[31], s3_slot_reg.out_min})
                + $signed({2'b00, s3_scaled_reg});
        if (s3_slot_reg.int_floor)
        begin
            s4_sum_next = {raw_sum[32:FRAC_BITS], {FRAC_BITS{1'b0}}};
        end
        else
        begin
            s4_sum_next = raw_sum;
        end
        s4_valid_next = s3_valid_reg;
        s4_last_next  = s3_last_reg;
        s4_slot_next  = s3_slot_reg;
    end

    // Stage 4: clamp to the port range, minimum tested first.
    always_comb
    begin
        lo_ext = {s4_slot_reg.out_min[31], s4_slot_reg.out_min};
        hi_ext = {s4_slot_reg.out_max[31], s4_slot_reg.out_max};
        if (s4_sum_reg < lo_ext)
        begin
            out_value_next = s4_slot_reg.out_min;
        end
        else if (s4_sum_reg > hi_ext)
        begin
            out_value_next = s4_slot_reg.out_max;
        end
        else
        begin
            out_value_next = s4_sum_reg[31:0];
        end
        out_valid_next = s4_valid_reg;
        out_last_next  = s4_last_reg;
        out_index_next = s4_slot_reg.target_port;
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_last_reg   <= s2_last_next;
            s2_rel_reg    <= s2_rel_next;
            s2_slot_reg   <= s2_slot_next;
            s3_last_reg   <= s3_last_next;
            s3_scaled_reg <= s3_scaled_next;
            s3_slot_reg   <= s3_slot_next;
            s4_last_reg   <= s4_last_next;
            s4_sum_reg    <= s4_sum_next;
            s4_slot_reg   <= s4_slot_next;
            out_last_reg  <= out_last_next;
            out_index_reg <= out_index_next;
            out_value_reg <= out_value_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.last       = out_last_reg;
    assign result.port_index = out_index_reg;
    assign result.port_value = out_value_reg;

    // The relative level never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_rel_reg <= REL_ONE[REL_W-1:0]))
        else $error("relative level above one");

    // The scaled level never exceeds the span.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_scaled_reg <= s3_slot_reg.out_span))
        else $error("scaled level above span");

    // With an ordered range the delivered value lies inside it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s4_valid_reg && (s4_slot_reg.out_min <= s4_slot_reg.out_max))
        |=> ((out_value_reg >= $past(s4_slot_reg.out_min))
             && (out_value_reg <= $past(s4_slot_reg.out_max))))
        else $error("port value outside its range");

endmodule

>>> rtl/core/midi_cc_automation_mapper.sv
// Top level of the MIDI controller automation mapper: slot tables, scanner and mapping.
//
// A load beat writes one automation slot; loads may follow one another in every cycle
// while the output does not stall. A control change event is matched against all
// valid slots at once, then a scanner walks the slots one per cycle from slot zero
// up to the highest matching slot h, reading that slot's mapping data from the slot
// memory; the next input beat is taken only once the scan has passed slot h, while
// an event that matches nothing, is not a control change or arrives while bypass is
// set does not hold off the next beat. The result of a matching slot reaches the
// output through the registered memory read and a four-stage mapping pipeline, at
// most one result beat per cycle, with last set on the final one. A stall on the
// output holds the whole pipeline and the scanner. Slot validity sits in flip-flops
// cleared by reset, so no clearing pass is needed.
module midi_cc_automation_mapper
    import mcam_pkg::*;
#(
    parameter int AUTOMATION_SLOTS = 8,
    parameter int FRAC_BITS        = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       bypass_we,
    input  logic       bypass_wdata,
    mcam_in_if.sink    item,
    mcam_out_if.source result
);

    localparam int IDX_W = (AUTOMATION_SLOTS > 1) ? $clog2(AUTOMATION_SLOTS) : 1;

    logic                        bypass_reg, bypass_next;
    logic [AUTOMATION_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [4:0]                  match_ch_reg [AUTOMATION_SLOTS];
    logic [7:0]                  match_cc_reg [AUTOMATION_SLOTS];
    mcam_slot_t                  slot_mem [AUTOMATION_SLOTS];
    mcam_slot_t                  rd_data_reg;

    logic [AUTOMATION_SLOTS-1:0] mask_reg, mask_next;
    logic [IDX_W-1:0]            cnt_reg, cnt_next;
    logic [7:0]                  cc_value_reg, cc_value_next;
    mcam_cand_t                  cand_reg, cand_next;

    logic                        advance;
    logic                        busy;
    logic                        accept;
    logic                        load_hit;
    logic                        scan_start;
    logic [IDX_W-1:0]            wr_idx;
    logic [7:0]                  status;
    logic [7:0]                  channel;
    logic [7:0]                  controller;
    logic                        is_cc;
    logic [AUTOMATION_SLOTS-1:0] hit_vec;
    mcam_slot_t                  wr_data;

    // Input handshake: a beat is taken only while no scan is running.
    assign busy       = |mask_reg;
    assign item.ready = advance && !busy;
    assign accept     = item.valid && item.ready;
    assign load_hit   = accept && (item.mode == MODE_LOAD)
                        && ({29'd0, item.slot} < 32'(AUTOMATION_SLOTS));
    assign wr_idx     = IDX_W'(item.slot);

    // MIDI message decoding.
    assign status     = item.midi_message[23:16];
    assign controller = item.midi_message[15:8];
    assign channel    = status & CHANNEL_MASK;
    assign is_cc      = (status & STATUS_KIND_MASK) == STATUS_CC;
    assign scan_start = accept && (item.mode == MODE_EVENT) && !bypass_reg && is_cc;

    // Match every slot against the event in parallel; negative codes other than
    // the wildcard never match.
    always_comb
    begin
        for (int k = 0; k < AUTOMATION_SLOTS; k++)
        begin
            hit_vec[k] = slot_valid_reg[k]
                && ((match_ch_reg[k] == ANY_CHANNEL)
                    || (match_ch_reg[k] == {1'b0, channel[3:0]}))
                && ((match_cc_reg[k] == ANY_CONTROLLER)
                    || (!match_cc_reg[k][7] && (match_cc_reg[k] == controller)));
        end
    end

    // Configuration and slot validity.
    always_comb
    begin
        bypass_next     = bypass_we ? bypass_wdata : bypass_reg;
        slot_valid_next = slot_valid_reg;
        if (load_hit)
        begin
            slot_valid_next[wr_idx] = 1'b1;
        end
    end

    // Scanner: the mask shifts one slot per cycle while the pipeline advances, bit zero
    // belongs to the slot the counter points at.
    always_comb
    begin
        mask_next     = mask_reg;
        cnt_next      = cnt_reg;
        cc_value_next = cc_value_reg;
        cand_next     = cand_reg;
        if (scan_start)
        begin
            mask_next     = hit_vec;
            cnt_next      = '0;
            cc_value_next = item.midi_message[7:0];
        end
        else if (busy && advance)
        begin
            mask_next = mask_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
        end
        if (advance)
        begin
            cand_next.valid    = busy && mask_reg[0];
            cand_next.last     = (mask_reg >> 1) == '0;
            cand_next.cc_value = cc_value_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg     <= 1'b0;
            slot_valid_reg <= '0;
            mask_reg       <= '0;
            cnt_reg        <= '0;
            cand_reg       <= '0;
        end
        else
        begin
            bypass_reg     <= bypass_next;
            slot_valid_reg <= slot_valid_next;
            mask_reg       <= mask_next;
            cnt_reg        <= cnt_next;
            cand_reg       <= cand_next;
        end
    end

    // Held controller value and match fields, one register pair per slot.
    always_ff @(posedge clk)
    begin
        cc_value_reg <= cc_value_next;
        if (load_hit)
        begin
            match_ch_reg[wr_idx] <= item.match_channel;
            match_cc_reg[wr_idx] <= item.match_controller;
        end
    end

    // Slot memory: written by loads, read by the scanner with a registered output.
    always_comb
    begin
        wr_data.cc_min      = item.cc_min;
        wr_data.cc_scale    = item.cc_scale;
        wr_data.target_port = item.target_port;
        wr_data.int_floor   = item.int_floor;
        wr_data.out_min     = item.out_min;
        wr_data.out_span    = item.out_span;
        wr_data.out_max     = item.out_max;
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            slot_mem[wr_idx] <= wr_data;
        end
        if (busy && advance)
        begin
            rd_data_reg <= slot_mem[cnt_reg];
        end
    end

    // Mapping pipeline.
    mcam_map_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cand      (cand_reg),
        .slot_data (rd_data_reg),
        .advance   (advance),
        .result    (result)
    );

    // A candidate is only issued from a slot that holds valid data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && advance && mask_reg[0]) |-> slot_valid_reg[cnt_reg])
        else $error("candidate issued from an invalid slot");

    // A running scan never points past the last slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ({{(32-IDX_W){1'b0}}, cnt_reg} < 32'(AUTOMATION_SLOTS)))
        else $error("scan counter beyond slot count");

    // Issuing the last candidate ends the scan and frees the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && advance && ((mask_reg >> 1) == '0)) |=> (!busy && cand_reg.last))
        else $error("scan did not end on its last candidate");

endmodule

>>> tb/sv/midi_cc_automation_mapper_tb.sv
// Self-checking testbench of the MIDI controller automation mapper: slot loads, CC events, bypass.
module midi_cc_automation_mapper_tb
    import mcam_pkg::*;
();

    localparam int SLOTS      = 8;
    localparam int FRAC       = 16;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE     = 12;

    // One beat of the input channel.
    typedef struct packed {
        logic               mode;
        logic [2:0]         slot;
        logic signed [4:0]  match_channel;
        logic signed [7:0]  match_controller;
        logic [6:0]         cc_min;
        logic [16:0]        cc_scale;
        logic [5:0]         target_port;
        logic signed [31:0] out_min;
        logic [30:0]        out_span;
        logic signed [31:0] out_max;
        logic               int_floor;
        logic [23:0]        midi_message;
    } item_beat_t;

    // One control port update on the output channel.
    typedef struct packed {
        logic [5:0]         port_index;
        logic signed [31:0] port_value;
        logic               last;
    } port_update_t;

    // Mirror of the slot tables that predicts the port updates of every event.
    class automation_scoreboard;
        bit             bypass_on;
        bit             slot_valid [SLOTS];
        logic [4:0]     slot_channel [SLOTS];
        logic [7:0]     slot_controller [SLOTS];
        mcam_slot_t     slot_data [SLOTS];
        port_update_t   pending_updates [$];
        int             errors;

        // Maps a controller value through one slot into a clamped Q16.16 port value.
        function automatic logic signed [31:0] mapped_value(mcam_slot_t s, logic [7:0] ccval);
            longint one;
            longint rel;
            longint lo;
            longint hi;
            longint v;
            one = longint'(1) << FRAC;
            rel = (longint'(ccval) - longint'(s.cc_min)) * longint'(s.cc_scale);
            if (rel < 0)
                rel = 0;
            else if (rel > one)
                rel = one;
            lo = longint'($signed(s.out_min));
            hi = longint'($signed(s.out_max));
            v = lo + ((rel * longint'(s.out_span)) >>> FRAC);
            // Integer ports drop the fraction, rounding toward minus infinity.
            if (s.int_floor)
                v = v & ~(one - 1);
            if (v < lo)
                v = lo;
            else if (v > hi)
                v = hi;
            return v[31:0];
        endfunction

        // Takes in one accepted input beat: a slot load or a MIDI event.
        function void apply_item(item_beat_t b);
            logic [7:0]   status;
            logic [7:0]   ctrl;
            logic [4:0]   chan;
            port_update_t hits [$];
            port_update_t u;
            if (b.mode == MODE_LOAD)
            begin
                slot_valid[b.slot]             = 1'b1;
                slot_channel[b.slot]           = b.match_channel;
                slot_controller[b.slot]        = b.match_controller;
                slot_data[b.slot].cc_min       = b.cc_min;
                slot_data[b.slot].cc_scale     = b.cc_scale;
                slot_data[b.slot].target_port  = b.target_port;
                slot_data[b.slot].int_floor    = b.int_floor;
                slot_data[b.slot].out_min      = b.out_min;
                slot_data[b.slot].out_span     = b.out_span;
                slot_data[b.slot].out_max      = b.out_max;
                return;
            end
            if (bypass_on)
                return;
            status = b.midi_message[23:16];
            if ((status & STATUS_KIND_MASK) != STATUS_CC)
                return;
            chan = {1'b0, status[3:0]};
            ctrl = b.midi_message[15:8];
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_valid[i])
                    continue;
                if (slot_channel[i] != ANY_CHANNEL && slot_channel[i] != chan)
                    continue;
                // A negative controller code other than the wildcard matches nothing.
                if (slot_controller[i] != ANY_CONTROLLER &&
                    (slot_controller[i][7] || slot_controller[i] != ctrl))
                    continue;
                u.port_index = slot_data[i].target_port;
                u.port_value = mapped_value(slot_data[i], b.midi_message[7:0]);
                u.last       = 1'b0;
                hits.push_back(u);
            end
            if (hits.size() > 0)
                hits[hits.size() - 1].last = 1'b1;
            foreach (hits[k])
                pending_updates.push_back(hits[k]);
        endfunction

        // Compares one accepted port update with the oldest prediction.
        function void check_update(port_update_t got);
            port_update_t want;
            if (pending_updates.size() == 0)
            begin
                $error("unexpected port update: port_index %0d port_value %0d last %0b",
                       got.port_index, got.port_value, got.last);
                errors++;
                return;
            end
            want = pending_updates.pop_front();
            if (got.port_index !== want.port_index)
            begin
                $error("port_index: expected %0d, got %0d", want.port_index, got.port_index);
                errors++;
            end
            if (got.port_value !== want.port_value)
            begin
                $error("port_value: expected %0d, got %0d", want.port_value, got.port_value);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic bypass_we;
    logic bypass_wdata;
    bit   calm;
    int   idle_cycles;

    automation_scoreboard sb;

    mcam_in_if  item_if ();
    mcam_out_if result_if ();

    midi_cc_automation_mapper #(
        .AUTOMATION_SLOTS (SLOTS),
        .FRAC_BITS        (FRAC)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .bypass_we    (bypass_we),
        .bypass_wdata (bypass_wdata),
        .item         (item_if),
        .result       (result_if)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length for either side: mostly short, now and then long, none in calm phases.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // A beat with every field random, as a base for loads and events.
    function automatic item_beat_t random_beat();
        item_beat_t b;
        b.mode             = 1'($urandom_range(0, 1));
        b.slot             = 3'($urandom);
        b.match_channel    = 5'($urandom);
        b.match_controller = 8'($urandom);
        b.cc_min           = 7'($urandom);
        b.cc_scale         = 17'($urandom);
        b.target_port      = 6'($urandom);
        b.out_min          = $urandom;
        b.out_span         = 31'($urandom);
        b.out_max          = $urandom;
        b.int_floor        = 1'($urandom);
        b.midi_message     = 24'($urandom);
        return b;
    endfunction

    function automatic item_beat_t slot_load(logic [2:0] s, logic [4:0] ch, logic [7:0] ctl,
                                             logic [6:0] ccmin, logic [16:0] scale,
                                             logic [5:0] port, logic [31:0] lo,
                                             logic [30:0] span, logic [31:0] hi,
                                             logic int_port);
        item_beat_t b;
        b = random_beat();
        b.mode             = MODE_LOAD;
        b.slot             = s;
        b.match_channel    = ch;
        b.match_controller = ctl;
        b.cc_min           = ccmin;
        b.cc_scale         = scale;
        b.target_port      = port;
        b.out_min          = lo;
        b.out_span         = span;
        b.out_max          = hi;
        b.int_floor        = int_port;
        return b;
    endfunction

    function automatic item_beat_t midi_event(logic [7:0] status, logic [7:0] ctl,
                                              logic [7:0] val);
        item_beat_t b;
        b = random_beat();
        b.mode         = MODE_EVENT;
        b.midi_message = {status, ctl, val};
        return b;
    endfunction

    // Random slot load with mostly sensible port ranges.
    function automatic item_beat_t random_load();
        item_beat_t b;
        int r;
        b = random_beat();
        b.mode = MODE_LOAD;
        r = $urandom_range(0, 9);
        b.match_channel = (r < 3) ? ANY_CHANNEL : (r < 9) ? 5'($urandom_range(0, 15))
                                                          : 5'($urandom);
        r = $urandom_range(0, 9);
        b.match_controller = (r < 3) ? ANY_CONTROLLER : (r < 9) ? 8'($urandom_range(0, 127))
                                                                : 8'($urandom);
        if ($urandom_range(0, 1))
            b.cc_min = 7'($urandom_range(0, 16));
        r = $urandom_range(0, 9);
        if (r == 0)
            b.cc_scale = '0;
        else if (r == 1)
            b.cc_scale = 17'h10000;
        else if (r != 2)
            b.cc_scale = 17'($urandom_range(256, 8192));
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            b.out_min  = int'($urandom_range(0, 32'h00c8_0000)) - 32'sh0064_0000;
            b.out_span = 31'($urandom_range(0, 32'h0064_0000));
            b.out_max  = b.out_min + $signed({1'b0, b.out_span});
        end
        else if (r < 8)
        begin
            // Minimum above maximum.
            b.out_min  = int'($urandom_range(0, 32'h0010_0000));
            b.out_span = 31'($urandom_range(0, 32'h0010_0000));
            b.out_max  = b.out_min - int'($urandom_range(1, 32'h0010_0000));
        end
        return b;
    endfunction

    // Random MIDI event, mostly a control change aimed at a loaded slot.
    function automatic item_beat_t random_event();
        item_beat_t b;
        logic [3:0] chan;
        logic [7:0] ctl;
        logic [7:0] val;
        int i;
        b = random_beat();
        b.mode = MODE_EVENT;
        i = $urandom_range(0, SLOTS - 1);
        chan = 4'($urandom);
        ctl  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        if ($urandom_range(0, 9) < 7 && sb.slot_valid[i])
        begin
            if (!sb.slot_channel[i][4])
                chan = sb.slot_channel[i][3:0];
            if (!sb.slot_controller[i][7])
                ctl = sb.slot_controller[i];
        end
        val = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
        if ($urandom_range(0, 9) < 8)
            b.midi_message = {STATUS_CC[7:4], chan, ctl, val};
        else
            b.midi_message = {8'($urandom), ctl, val};
        return b;
    endfunction

    // Drives one beat and returns at the edge where it is accepted.
    task automatic send_item(input item_beat_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid            <= 1'b1;
        item_if.mode             <= b.mode;
        item_if.slot             <= b.slot;
        item_if.match_channel    <= b.match_channel;
        item_if.match_controller <= b.match_controller;
        item_if.cc_min           <= b.cc_min;
        item_if.cc_scale         <= b.cc_scale;
        item_if.target_port      <= b.target_port;
        item_if.out_min          <= b.out_min;
        item_if.out_span         <= b.out_span;
        item_if.out_max          <= b.out_max;
        item_if.int_floor        <= b.int_floor;
        item_if.midi_message     <= b.midi_message;
        do
            @(posedge clk);
        while (!item_if.ready);
    endtask

    // Holds the sender until every predicted update has come out.
    task automatic hold_until_drained();
        item_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_updates.size() != 0);
    endtask

    // Brings the block to idle, then writes the bypass register.
    task automatic write_bypass(input logic value);
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        bypass_we    <= 1'b1;
        bypass_wdata <= value;
        sb.bypass_on = value;
        @(posedge clk);
        bypass_we <= 1'b0;
    endtask

    // Ready side: random stalls on the result channel.
    initial
    begin
        int n;
        result_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Beat monitors on both channels and the watchdog on idle cycles.
    always @(posedge clk)
    begin
        item_beat_t   seen;
        port_update_t upd;
        bit           moved;
        moved = 1'b0;
        if (rst_n && item_if.valid && item_if.ready)
        begin
            seen.mode             = item_if.mode;
            seen.slot             = item_if.slot;
            seen.match_channel    = item_if.match_channel;
            seen.match_controller = item_if.match_controller;
            seen.cc_min           = item_if.cc_min;
            seen.cc_scale         = item_if.cc_scale;
            seen.target_port      = item_if.target_port;
            seen.out_min          = item_if.out_min;
            seen.out_span         = item_if.out_span;
            seen.out_max          = item_if.out_max;
            seen.int_floor        = item_if.int_floor;
            seen.midi_message     = item_if.midi_message;
            sb.apply_item(seen);
            moved = 1'b1;
        end
        if (rst_n && result_if.valid && result_if.ready)
        begin
            upd.port_index = result_if.port_index;
            upd.port_value = result_if.port_value;
            upd.last       = result_if.last;
            sb.check_update(upd);
            moved = 1'b1;
        end
        if (!rst_n || moved)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: directed cases, a bypass check, then random phases.
    initial
    begin
        sb = new;
        calm = 1'b0;
        idle_cycles = 0;
        rst_n        <= 1'b0;
        bypass_we    <= 1'b0;
        bypass_wdata <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.mode             <= MODE_LOAD;
        item_if.slot             <= '0;
        item_if.match_channel    <= '0;
        item_if.match_controller <= '0;
        item_if.cc_min           <= '0;
        item_if.cc_scale         <= '0;
        item_if.target_port      <= '0;
        item_if.out_min          <= '0;
        item_if.out_span         <= '0;
        item_if.out_max          <= '0;
        item_if.int_floor        <= 1'b0;
        item_if.midi_message     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An event with no slot loaded gives nothing.
        send_item(midi_event(STATUS_CC, 8'd0, 8'd0));
        // Catch-all slot over a 0..100 range.
        send_item(slot_load(3'd0, ANY_CHANNEL, ANY_CONTROLLER, 7'd0, 17'd516, 6'd0,
                            32'h0000_0000, 31'h0064_0000, 32'h0064_0000, 1'b0));
        // Integer port whose floor drops below the minimum.
        send_item(slot_load(3'd1, 5'd3, 8'd7, 7'd10, 17'h10000, 6'd5,
                            32'hfffb_8000, 31'h0014_0000, 32'h0010_0000, 1'b1));
        // Minimum above maximum.
        send_item(slot_load(3'd2, ANY_CHANNEL, 8'd7, 7'd0, 17'h10000, 6'd9,
                            32'h000a_0000, 31'h0001_0000, 32'h0002_0000, 1'b0));
        // Negative match codes other than the wildcard never match.
        send_item(slot_load(3'd3, 5'h1e, ANY_CONTROLLER, 7'd0, 17'h10000, 6'd1,
                            32'h0, 31'h0001_0000, 32'h0001_0000, 1'b0));
        send_item(slot_load(3'd4, 5'd3, 8'h80, 7'd0, 17'h10000, 6'd2,
                            32'h0, 31'h0001_0000, 32'h0001_0000, 1'b0));
        // Extreme ranges, zero scale and the top cc_min.
        send_item(slot_load(3'd5, 5'd15, 8'd127, 7'd127, 17'd0, 6'd63,
                            32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 1'b1));
        send_item(slot_load(3'd6, 5'd15, ANY_CONTROLLER, 7'd0, 17'h1ffff, 6'd42,
                            32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        send_item(midi_event({STATUS_CC[7:4], 4'd3}, 8'd7, 8'd0));
        send_item(midi_event({STATUS_CC[7:4], 4'd3}, 8'd7, 8'd127));
        // Data byte above 127 is used as it stands.
        send_item(midi_event({STATUS_CC[7:4], 4'd3}, 8'd7, 8'd255));
        send_item(midi_event({STATUS_CC[7:4], 4'd3}, 8'd8, 8'd64));
        send_item(midi_event({STATUS_CC[7:4], 4'd15}, 8'd127, 8'd127));
        send_item(midi_event({STATUS_CC[7:4], 4'd15}, 8'd200, 8'd3));
        // Messages other than control change give nothing.
        send_item(midi_event(8'h93, 8'd7, 8'd64));
        send_item(midi_event(8'hff, 8'hff, 8'hff));
        send_item(slot_load(3'd7, 5'd0, 8'd0, 7'd64, 17'd1024, 6'd17,
                            32'hfffd_0000, 31'h0006_0000, 32'h0003_0000, 1'b1));
        send_item(midi_event({STATUS_CC[7:4], 4'd0}, 8'd0, 8'd32));
        send_item(midi_event({STATUS_CC[7:4], 4'd0}, 8'd0, 8'd100));
        // Overwrite the catch-all slot with a narrow match.
        send_item(slot_load(3'd0, 5'd1, 8'd1, 7'd0, 17'd516, 6'd30,
                            32'h0000_0000, 31'h0064_0000, 32'h0064_0000, 1'b0));
        send_item(midi_event({STATUS_CC[7:4], 4'd3}, 8'd7, 8'd64));
        send_item(midi_event({STATUS_CC[7:4], 4'd2}, 8'd2, 8'd5));

        // Bypass blocks events but not loads.
        write_bypass(1'b1);
        send_item(midi_event({STATUS_CC[7:4], 4'd3}, 8'd7, 8'd64));
        send_item(slot_load(3'd3, ANY_CHANNEL, ANY_CONTROLLER, 7'd0, 17'h10000, 6'd11,
                            32'h0, 31'h0001_0000, 32'h0001_0000, 1'b0));
        send_item(midi_event({STATUS_CC[7:4], 4'd15}, 8'd127, 8'd127));
        write_bypass(1'b0);

        // Random phases; some run with no idling on either side.
        for (int phase = 0; phase < 8; phase++)
        begin
            calm = (phase == 2 || phase == 5);
            for (int k = 0; k < 35; k++)
            begin
                if ($urandom_range(0, 99) < ((phase == 0) ? 50 : 25))
                    send_item(random_load());
                else
                    send_item(random_event());
                if ($urandom_range(0, 39) == 0)
                    hold_until_drained();
            end
            write_bypass((phase == 3) || ($urandom_range(0, 4) == 0));
        end
        calm = 1'b0;
        write_bypass(1'b0);
        for (int k = 0; k < 20; k++)
            send_item(random_event());

        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending_updates.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> midi_cc_automation_mapper.f
rtl/core/mcam_pkg.sv
rtl/core/mcam_in_if.sv
rtl/core/mcam_out_if.sv
rtl/core/mcam_map_pipe.sv
rtl/core/midi_cc_automation_mapper.sv
tb/sv/midi_cc_automation_mapper_tb.sv
